// ===== rtl/atp_pkg.sv =====
// Shared types, constants and helper functions for the atan(x)/pi pipeline.
// No dependencies; used by the interfaces' users, the FMA unit and the top level.
`timescale 1ns / 1ps

package atp_pkg;

  localparam int FMA_LAT    = 9;
  localparam int DIV_STAGES = 13;

  localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] FP_HALF     = 32'h3f00_0000;
  localparam logic [31:0] FP_ONE      = 32'h3f80_0000;
  localparam logic [31:0] FP_INF      = 32'h7f80_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

  // Polynomial coefficients in binary32.
  localparam logic [31:0] K0 = 32'h3ea2_f983;
  localparam logic [31:0] K1 = 32'hbdd9_4baf;
  localparam logic [31:0] K2 = 32'h3d82_4872;
  localparam logic [31:0] K3 = 32'hbd38_6139;
  localparam logic [31:0] K4 = 32'h3d07_77a9;
  localparam logic [31:0] K5 = 32'hbcb5_5ddd;
  localparam logic [31:0] K6 = 32'h3c3c_0ab8;
  localparam logic [31:0] K7 = 32'hbb78_5a03;
  localparam logic [31:0] K8 = 32'h3a15_73ff;

  typedef struct packed {
    logic               sign;
    logic               zero;
    logic signed [11:0] expo;
    logic [23:0]        mant;
  } fp_unp_t;

  function automatic logic [4:0] lzc24(logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc52(logic [51:0] v);
    logic [5:0] n;
    n = 6'd52;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) n = 6'(51 - i);
    end
    return n;
  endfunction

  // Subnormals are normalized so that the significand always has its top bit set.
  function automatic fp_unp_t fp_unpack(logic [31:0] f);
    logic [23:0] m;
    logic [4:0]  lz;
    logic [11:0] e_eff;
    fp_unp_t     u;
    m     = {(f[30:23] != 8'd0), f[22:0]};
    lz    = lzc24(m);
    e_eff = (f[30:23] == 8'd0) ? 12'd1 : {4'd0, f[30:23]};
    u.sign = f[31];
    u.zero = (f[30:0] == 31'd0);
    u.mant = m << lz;
    u.expo = signed'(e_eff - {7'd0, lz});
    return u;
  endfunction

  // The exponent field is one less than the biased exponent for normal results,
  // so the hidden bit and a rounding carry both ripple into it.
  function automatic logic [31:0] round_pack(logic sign, logic [7:0] ef, logic [23:0] m,
                                             logic g, logic s);
    logic [24:0] mr;
    logic [30:0] mag;
    mr  = {1'b0, m} + {24'd0, g & (s | m[0])};
    mag = {ef, 23'd0} + {6'd0, mr};
    return {sign, mag};
  endfunction

endpackage

// ===== rtl/atp_if.sv =====
// Valid/ready stream interfaces for the argument and result channels.
// No dependencies.
`timescale 1ns / 1ps

interface atp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;
  modport source(output valid, output x_bits, input ready);
  modport sink(input valid, input x_bits, output ready);
endinterface

interface atp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source(output valid, output result_bits, input ready);
  modport sink(input valid, input result_bits, output ready);
endinterface

// ===== rtl/atp_fma.sv =====
// Pipelined binary32 fused multiply-add for finite operands, one rounding.
// Depends on atp_pkg; the pipeline advances only on enabled clocks.
`timescale 1ns / 1ps

module atp_fma import atp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic [31:0] r
);

  typedef struct packed {
    logic        pz;
    logic        cz;
    logic        sp;
    logic        sc;
    logic [31:0] c;
  } fma_side_t;

  // stage 1: unpacked operands
  fp_unp_t s1_a_r, s1_b_r, s1_c_r;
  logic [31:0] s1_craw_r;
  // stage 2: product
  fma_side_t s2_side_r;
  logic [47:0] s2_prod_r;
  logic signed [11:0] s2_ep_r, s2_ec_r;
  logic [23:0] s2_cm_r;
  // stage 3: aligned operands
  fma_side_t s3_side_r;
  logic [50:0] s3_xw_r, s3_yal_r;
  logic signed [11:0] s3_ex_r;
  logic s3_sx_r, s3_sub_r;
  // stage 4: raw sum
  fma_side_t s4_side_r;
  logic [52:0] s4_sum_r;
  logic signed [11:0] s4_ex_r;
  logic s4_sx_r;
  // stage 5: magnitude
  fma_side_t s5_side_r;
  logic [51:0] s5_mag_r;
  logic signed [11:0] s5_ex_r;
  logic s5_rs_r;
  // stage 6: leading zero count
  fma_side_t s6_side_r;
  logic [51:0] s6_mag_r;
  logic [5:0] s6_lz_r;
  logic signed [11:0] s6_ex_r;
  logic s6_rs_r, s6_zero_r;
  // stage 7: normalized
  fma_side_t s7_side_r;
  logic [51:0] s7_sn_r;
  logic signed [11:0] s7_eb_r;
  logic s7_rs_r, s7_zero_r;
  // stage 8: denormalized and split for rounding
  fma_side_t s8_side_r;
  logic [23:0] s8_m_r;
  logic [7:0] s8_ef_r;
  logic s8_g_r, s8_s_r, s8_rs_r, s8_zero_r;
  // stage 9: packed result
  logic [31:0] s9_r_r;

  fma_side_t side1;
  logic [47:0] xm, ym;
  logic signed [11:0] ex, ey, diff, rsh12;
  logic sx, sy;
  logic [5:0] sh, rsh;
  logic [114:0] yshift;
  logic [50:0] yal;
  logic [115:0] dshift;
  logic [51:0] sd;
  logic dst;
  logic [7:0] ef;
  logic [31:0] r_nxt;

  always_comb begin
    side1.pz = s1_a_r.zero | s1_b_r.zero;
    side1.cz = s1_c_r.zero;
    side1.sp = s1_a_r.sign ^ s1_b_r.sign;
    side1.sc = s1_c_r.sign;
    side1.c  = s1_craw_r;
  end

  // Larger exponent goes first; a zero addend never needs a shift.
  always_comb begin
    if (s2_side_r.cz || (s2_ep_r >= s2_ec_r)) begin
      xm = s2_prod_r;
      ex = s2_ep_r;
      sx = s2_side_r.sp;
      ym = s2_side_r.cz ? 48'd0 : {s2_cm_r, 24'd0};
      ey = s2_ec_r;
      sy = s2_side_r.sc;
    end else begin
      xm = {s2_cm_r, 24'd0};
      ex = s2_ec_r;
      sx = s2_side_r.sc;
      ym = s2_prod_r;
      ey = s2_ep_r;
      sy = s2_side_r.sp;
    end
    diff = ex - ey;
    if (s2_side_r.cz) begin
      sh = 6'd0;
    end else if (diff > 12'sd63) begin
      sh = 6'd63;
    end else begin
      sh = diff[5:0];
    end
    yshift = {ym, 3'b000, 64'd0} >> sh;
    yal    = {yshift[114:65], yshift[64] | (|yshift[63:0])};
  end

  // Results below the normal range shift right to the subnormal grid.
  always_comb begin
    rsh12 = 12'sd1 - s7_eb_r;
    if (rsh12 > 12'sd63) begin
      rsh = 6'd63;
    end else begin
      rsh = rsh12[5:0];
    end
    if (s7_eb_r < 12'sd1) begin
      dshift = {s7_sn_r, 64'd0} >> rsh;
      sd     = dshift[115:64];
      dst    = |dshift[63:0];
      ef     = 8'd0;
    end else begin
      dshift = '0;
      sd     = s7_sn_r;
      dst    = 1'b0;
      ef     = 8'(s7_eb_r - 12'sd1);
    end
  end

  always_comb begin
    if (s8_side_r.pz && s8_side_r.cz) begin
      r_nxt = {s8_side_r.sp & s8_side_r.sc, 31'd0};
    end else if (s8_side_r.pz) begin
      r_nxt = s8_side_r.c;
    end else if (s8_zero_r) begin
      r_nxt = 32'd0;
    end else begin
      r_nxt = round_pack(s8_rs_r, s8_ef_r, s8_m_r, s8_g_r, s8_s_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r    <= fp_unpack(a);
      s1_b_r    <= fp_unpack(b);
      s1_c_r    <= fp_unpack(c);
      s1_craw_r <= c;

      s2_side_r <= side1;
      s2_prod_r <= s1_a_r.mant * s1_b_r.mant;
      s2_ep_r   <= s1_a_r.expo + s1_b_r.expo - 12'sd300;
      s2_ec_r   <= s1_c_r.expo - 12'sd174;
      s2_cm_r   <= s1_c_r.mant;

      s3_side_r <= s2_side_r;
      s3_xw_r   <= {xm, 3'b000};
      s3_yal_r  <= yal;
      s3_ex_r   <= ex;
      s3_sx_r   <= sx;
      s3_sub_r  <= sx ^ sy;

      s4_side_r <= s3_side_r;
      s4_sum_r  <= s3_sub_r ? ({2'b00, s3_xw_r} - {2'b00, s3_yal_r})
                            : ({2'b00, s3_xw_r} + {2'b00, s3_yal_r});
      s4_ex_r   <= s3_ex_r;
      s4_sx_r   <= s3_sx_r;

      s5_side_r <= s4_side_r;
      s5_mag_r  <= s4_sum_r[52] ? (~s4_sum_r[51:0] + 52'd1) : s4_sum_r[51:0];
      s5_ex_r   <= s4_ex_r;
      s5_rs_r   <= s4_sx_r ^ s4_sum_r[52];

      s6_side_r <= s5_side_r;
      s6_mag_r  <= s5_mag_r;
      s6_lz_r   <= lzc52(s5_mag_r);
      s6_ex_r   <= s5_ex_r;
      s6_rs_r   <= s5_rs_r;
      s6_zero_r <= (s5_mag_r == 52'd0);

      s7_side_r <= s6_side_r;
      s7_sn_r   <= s6_mag_r << s6_lz_r;
      s7_eb_r   <= s6_ex_r + 12'sd175 - signed'({6'd0, s6_lz_r});
      s7_rs_r   <= s6_rs_r;
      s7_zero_r <= s6_zero_r;

      s8_side_r <= s7_side_r;
      s8_m_r    <= sd[51:28];
      s8_g_r    <= sd[27];
      s8_s_r    <= (|sd[26:0]) | dst;
      s8_ef_r   <= ef;
      s8_rs_r   <= s7_rs_r;
      s8_zero_r <= s7_zero_r;

      s9_r_r    <= r_nxt;
    end
  end

  assign r = s9_r_r;

endmodule

// ===== rtl/atanpi_float32_approx.sv =====
// atan(x)/pi in binary32: a result passes 13 reciprocal stages of two quotient bits each
// and six chained FMA levels. Throughput is one request per cycle while the skid stage
// is empty; an output register plus a skid stage keep input acceptance going while a
// result waits. Synchronous active-low reset clears only valid bits; there is no
// clearing pass. Depends on atp_pkg, atp_if, atp_fma.
`timescale 1ns / 1ps

module atanpi_float32_approx import atp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  atp_in_if.sink           in_ch,
  atp_out_if.source        out_ch
);

  localparam int VLEN   = 1 + DIV_STAGES + 1 + 6 * FMA_LAT;
  localparam int XZ_DLY = 6 * FMA_LAT;
  localparam int XZ_TAP = 5 * FMA_LAT - 1;
  localparam int Z2_DLY = 3 * FMA_LAT;
  localparam logic [24:0] DIV_REM_INIT = 25'h080_0000;

  logic en;
  logic [VLEN-1:0] vld_r;
  logic [31:0] x0_r;
  logic [24:0] drem_r [DIV_STAGES];
  logic [25:0] dq_r   [DIV_STAGES];
  logic [31:0] dx_r   [DIV_STAGES];
  logic [31:0] zs_x_r, zs_z_r;
  logic [63:0] xz_dly_r [XZ_DLY];
  logic [31:0] z2_dly_r [Z2_DLY];
  logic out_valid_r, skid_valid_r;
  logic [31:0] out_data_r, skid_data_r;

  // One restoring step: quotient bit on top, shifted remainder below.
  function automatic logic [25:0] div_step(logic [24:0] rem, logic [23:0] m);
    logic [24:0] d;
    logic        q;
    q = (rem >= {1'b0, m});
    d = q ? (rem - {1'b0, m}) : rem;
    return {q, d[23:0], 1'b0};
  endfunction

  assign en = ~skid_valid_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [24:0] rem_in;
    logic [25:0] q_in, st1, st2;
    logic [31:0] x_in;
    logic [23:0] m_in;
    if (g == 0) begin : g_first
      assign rem_in = DIV_REM_INIT;
      assign q_in   = '0;
      assign x_in   = x0_r;
    end else begin : g_next
      assign rem_in = drem_r[g-1];
      assign q_in   = dq_r[g-1];
      assign x_in   = dx_r[g-1];
    end
    assign m_in = {1'b1, x_in[22:0]};
    assign st1  = div_step(rem_in, m_in);
    assign st2  = div_step(st1[24:0], m_in);
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[g] <= st2[24:0];
        dq_r[g]   <= {q_in[23:0], st1[25], st2[25]};
        dx_r[g]   <= x_in;
      end
    end
  end

  // Round the reciprocal; a quotient of exactly one only occurs for a power of two.
  logic [25:0] q_fin, tman;
  logic [24:0] rem_fin;
  logic [31:0] xd, recip, z_sel;
  logic signed [9:0] eb;
  logic [1:0] rsh2;
  logic [27:0] tw;
  logic [7:0] ef;
  logic st;

  always_comb begin
    q_fin   = dq_r[DIV_STAGES-1];
    rem_fin = drem_r[DIV_STAGES-1];
    xd      = dx_r[DIV_STAGES-1];
    tman    = q_fin[25] ? q_fin : {q_fin[24:0], 1'b0};
    eb      = (q_fin[25] ? 10'sd254 : 10'sd253) - signed'({2'b00, xd[30:23]});
    rsh2    = (eb < 10'sd1) ? 2'(10'sd1 - eb) : 2'd0;
    tw      = {tman, 2'b00} >> rsh2;
    st      = (|tw[1:0]) | (rem_fin != 25'd0);
    ef      = (eb >= 10'sd1) ? 8'(eb - 10'sd1) : 8'd0;
    recip   = round_pack(~xd[31], ef, tw[27:4], tw[3], (|tw[2:0]) | st);
    if (xd[30:0] <= FP_ONE[30:0]) begin
      z_sel = xd;
    end else if (xd[30:0] == FP_INF[30:0]) begin
      z_sel = {~xd[31], 31'd0};
    end else begin
      z_sel = recip;
    end
  end

  logic [31:0] z2, z4, p12, p34, p56, p78, z8, p14, p58, y1, y2, r6;
  logic [31:0] x_tap, z_tap, x_end, shift_val, pd;

  assign x_tap     = xz_dly_r[XZ_TAP][63:32];
  assign z_tap     = xz_dly_r[XZ_TAP][31:0];
  assign x_end     = xz_dly_r[XZ_DLY-1][63:32];
  assign shift_val = {x_tap[31], (x_tap[30:0] > FP_ONE[30:0]) ? FP_HALF[30:0] : 31'd0};

  atp_fma u_z2  (.clk(clk), .en(en), .a(zs_z_r), .b(zs_z_r), .c(FP_NEG_ZERO), .r(z2));
  atp_fma u_z4  (.clk(clk), .en(en), .a(z2), .b(z2), .c(FP_NEG_ZERO), .r(z4));
  atp_fma u_p12 (.clk(clk), .en(en), .a(z2), .b(K2), .c(K1), .r(p12));
  atp_fma u_p34 (.clk(clk), .en(en), .a(z2), .b(K4), .c(K3), .r(p34));
  atp_fma u_p56 (.clk(clk), .en(en), .a(z2), .b(K6), .c(K5), .r(p56));
  atp_fma u_p78 (.clk(clk), .en(en), .a(z2), .b(K8), .c(K7), .r(p78));
  atp_fma u_z8  (.clk(clk), .en(en), .a(z4), .b(z4), .c(FP_NEG_ZERO), .r(z8));
  atp_fma u_p14 (.clk(clk), .en(en), .a(z4), .b(p34), .c(p12), .r(p14));
  atp_fma u_p58 (.clk(clk), .en(en), .a(z4), .b(p78), .c(p56), .r(p58));
  atp_fma u_y1  (.clk(clk), .en(en), .a(z8), .b(p58), .c(p14), .r(y1));
  atp_fma u_y2  (.clk(clk), .en(en), .a(z2_dly_r[Z2_DLY-1]), .b(y1), .c(K0), .r(y2));
  atp_fma u_r   (.clk(clk), .en(en), .a(z_tap), .b(y2), .c(shift_val), .r(r6));

  // A NaN argument comes back quieted with its payload.
  assign pd = ((x_end[30:23] == 8'hff) && (x_end[22:0] != 23'd0)) ? (x_end | QUIET_BIT) : r6;

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r   <= in_ch.x_bits;
      zs_x_r <= xd;
      zs_z_r <= z_sel;
      xz_dly_r[0] <= {zs_x_r, zs_z_r};
      for (int i = 1; i < XZ_DLY; i++) xz_dly_r[i] <= xz_dly_r[i-1];
      z2_dly_r[0] <= z2;
      for (int i = 1; i < Z2_DLY; i++) z2_dly_r[i] <= z2_dly_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[VLEN-2:0], in_ch.valid};
      if (vld_r[VLEN-1]) begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
          out_data_r  <= pd;
        end else begin
          skid_valid_r <= 1'b1;
          skid_data_r  <= pd;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end else if (out_ch.ready) begin
      out_data_r   <= skid_data_r;
      skid_valid_r <= 1'b0;
    end
  end

  assign in_ch.ready        = en;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_bits = out_data_r;

endmodule

// ===== rtl/atp_checker.sv =====
// Port-level checks on the atan(x)/pi block, bound to its top level.
// Depends on atanpi_float32_approx and the atp_if interfaces.
`timescale 1ns / 1ps

module atp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_bits
);

  logic [7:0] pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'd0;
    end else begin
      pending_r <= pending_r + {7'd0, in_valid & in_ready} - {7'd0, out_valid & out_ready};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bits))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 8'd0)
    else $error("result without an outstanding request");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with an empty output");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind atanpi_float32_approx atp_checker u_atp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_bits(out_ch.result_bits)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for atanpi_float32_approx: directed and random binary32 arguments.
// It predicts each atan(x)/pi bit pattern in IEEE double arithmetic and compares it in order.
// Depends on atp_pkg, atp_if and the RTL top level.
`timescale 1ns / 1ps

class atanpi_scoreboard;
  logic [31:0] expected_atanpi[$];
  int          mismatches;
  int          results_seen;

  function new();
    mismatches   = 0;
    results_seen = 0;
  endfunction

  // Widen a binary32 pattern to a double value exactly.
  function real widen(logic [31:0] f);
    logic [63:0] d;
    logic [22:0] fr;
    int          e;
    fr = f[22:0];
    e  = f[30:23];
    if (e == 255) begin
      d = {f[31], 11'h7ff, fr, 29'd0};
    end else if (e == 0 && fr == 0) begin
      d = {f[31], 63'd0};
    end else if (e == 0) begin
      e = 1;
      while (!fr[22]) begin
        fr = fr << 1;
        e  = e - 1;
      end
      fr = fr << 1;
      d  = {f[31], 11'(e - 127 + 1023 - 1), fr, 29'd0};
    end else begin
      d = {f[31], 11'(e - 127 + 1023), fr, 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  // Round a double to binary32 with round-to-nearest-even, subnormals kept.
  function logic [31:0] narrow(real r);
    logic [63:0] d;
    logic [52:0] sig;
    logic [52:0] keep;
    logic [31:0] mag;
    logic        g, s;
    int          fe, a, ebase;
    d = $realtobits(r);
    if (d[62:52] == 11'h7ff) return {d[63], 8'hff, d[51:29]};
    if (d[62:52] == 0) return {d[63], 31'd0};
    sig = {1'b1, d[51:0]};
    fe  = int'(d[62:52]) - 1023 + 127;
    if (fe >= 1) begin
      a     = 29;
      ebase = fe - 1;
    end else begin
      a     = 30 - fe;
      ebase = 0;
    end
    // Past this shift even the guard bit lies below the significand.
    if (a > 53) begin
      keep = 0;
      g    = 0;
      s    = 1;
    end else begin
      keep = sig >> a;
      g    = sig[a-1];
      s    = (sig & ((53'd1 << (a - 1)) - 1)) != 0;
    end
    keep = keep + (g & (s | keep[0]));
    if (ebase >= 255) return {d[63], 31'h7f80_0000};
    mag = (32'(ebase) << 23) + keep[31:0];
    if (mag >= 32'h7f80_0000) mag = 32'h7f80_0000;
    return {d[63], mag[30:0]};
  endfunction

  function logic [31:0] mul_f(logic [31:0] a, logic [31:0] b);
    return narrow(widen(a) * widen(b));
  endfunction

  // Fused a*b+c: exact double product, sum rounded to odd, then one binary32 rounding.
  function logic [31:0] fma_f(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    real         p, cd, sum, bv, err;
    logic [63:0] sb;
    p   = widen(a) * widen(b);
    cd  = widen(c);
    sum = p + cd;
    if (sum - sum != 0.0) return narrow(sum);
    bv  = sum - p;
    err = (p - (sum - bv)) + (cd - bv);
    if (err != 0.0) begin
      sb = $realtobits(sum);
      if (!sb[0]) begin
        if ((err > 0.0) == (sum > 0.0)) sb = sb + 1;
        else sb = sb - 1;
        sum = $bitstoreal(sb);
      end
    end
    return narrow(sum);
  endfunction

  function logic [31:0] atanpi_of(logic [31:0] x);
    logic [31:0] z, shift, z2, z4, z8, p12, p34, p56, p78, p14, p58, y;
    logic        reduce;
    if (x[30:23] == 8'hff && x[22:0] != 0) return x | atp_pkg::QUIET_BIT;
    reduce = x[30:0] > atp_pkg::FP_ONE[30:0];
    z      = reduce ? narrow(-1.0 / widen(x)) : x;
    shift  = (reduce ? atp_pkg::FP_HALF : 32'd0) ^ (x & atp_pkg::FP_NEG_ZERO);
    z2  = mul_f(z, z);
    z4  = mul_f(z2, z2);
    z8  = mul_f(z4, z4);
    p12 = fma_f(z2, atp_pkg::K2, atp_pkg::K1);
    p34 = fma_f(z2, atp_pkg::K4, atp_pkg::K3);
    p56 = fma_f(z2, atp_pkg::K6, atp_pkg::K5);
    p78 = fma_f(z2, atp_pkg::K8, atp_pkg::K7);
    p14 = fma_f(z4, p34, p12);
    p58 = fma_f(z4, p78, p56);
    y   = fma_f(z8, p58, p14);
    y   = fma_f(z2, y, atp_pkg::K0);
    return fma_f(z, y, shift);
  endfunction

  function void note_request(logic [31:0] x);
    expected_atanpi.push_back(atanpi_of(x));
  endfunction

  function void check_result(logic [31:0] r);
    logic [31:0] want;
    results_seen++;
    if (expected_atanpi.size() == 0) begin
      $display("%0t: unexpected result %h", $time, r);
      mismatches++;
      return;
    end
    want = expected_atanpi.pop_front();
    if (r !== want) begin
      $display("%0t: result_bits expected %h actual %h", $time, want, r);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  atp_in_if         in_ch();
  atp_out_if        out_ch();
  atanpi_scoreboard board = new();
  bit               calm = 1'b0;
  int               requests_taken = 0;
  int               quiet_cycles = 0;

  atanpi_float32_approx uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      board.note_request(in_ch.x_bits);
      requests_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.result_bits);
  end

  // Watchdog on cycles in which neither channel moves a request or a result.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d results still pending", $time,
                 board.expected_atanpi.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(logic [31:0] x);
    if (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.x_bits <= x;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] random_argument();
    logic [31:0] x;
    int          pick;
    x    = $urandom;
    pick = $urandom_range(99);
    // About half the arguments sit around |x| = 1 where both branches and the polynomial matter.
    if (pick < 45) x[30:23] = 8'($urandom_range(134, 115));
    else if (pick < 55) x[30:23] = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
    else if (pick < 60) x[30:0] = 31'h3f80_0000 + 31'($urandom_range(4)) - 31'd2;
    return x;
  endfunction

  initial begin
    logic [31:0] directed[$];
    in_ch.valid  = 1'b0;
    in_ch.x_bits = 32'd0;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
                 32'h3f80_0001, 32'hbf7f_ffff, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0000, 32'h7f80_0001, 32'hffa5_5aa5, 32'h0000_0001,
                 32'h807f_ffff, 32'h0080_0000, 32'h7f7f_ffff, 32'hff7f_ffff,
                 32'h3f00_0000, 32'hc000_0000, 32'h4b80_0000, 32'h3380_0000,
                 32'h7e80_0000, 32'h0040_0000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_request(directed[i]);
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 230);
      send_request(random_argument());
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;
    while (board.expected_atanpi.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d arguments (signed zeros, unit magnitude, subnormals, infinities, NaNs)",
             requests_taken);
    $display("and checked %0d results under random stalls on both channels.",
             board.results_seen);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/atp_pkg.sv
rtl/atp_if.sv
rtl/atp_fma.sv
rtl/atanpi_float32_approx.sv
rtl/atp_checker.sv
sim/testbench.sv
